>>> hdl/sbb_pkg.sv
// Shared constants for the separable box blur: sequencer states, item kinds, register indexes and widths.
`default_nettype none
package sbb_pkg;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TAP  = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_ADV  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_PUT  = 3'd6;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam int CFG_DW = 11;
    localparam int PIX_W  = 16;
endpackage
`default_nettype wire

>>> hdl/sbb_if.sv
// Valid/ready channel interfaces for pixel input, blurred output and configuration.
`default_nettype none
interface sbb_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] pixel;
    modport source (output valid, kind, pixel, input ready);
    modport sink   (input valid, kind, pixel, output ready);
endinterface

interface sbb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] blurred;
    logic        frame_end;
    modport source (output valid, blurred, frame_end, input ready);
    modport sink   (input valid, blurred, frame_end, output ready);
endinterface

interface sbb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/sbb_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module sbb_div #(
    parameter int DW = 22,
    parameter int NW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [NW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);
    localparam int KW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_d;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [NW:0]   trial;

    assign trial = {r_rem, r_q[DW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_d}) begin
                r_rem <= NW'(trial - {1'b0, r_d});
                r_q   <= {r_q[DW-2:0], 1'b1};
            end else begin
                r_rem <= trial[NW-1:0];
                r_q   <= {r_q[DW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule
`default_nettype wire

>>> hdl/separable_box_blur_core.sv
// Two-pass separable box blur core with a shared tap accumulator and divider.
// Each horizontal or vertical mean sums 2r+1 taps, then a settle state, then the shared
// divider; an item runs zero to r+2 of these means. A new item is taken only in idle,
// once the previous item is done. Reset (synchronous, active low) clears state, counters
// and flags and restores config defaults; line stores and data registers are not cleared.
`default_nettype none
module separable_box_blur_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 15
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sbb_in_if.sink    i_pix,
    sbb_out_if.source o_res,
    sbb_cfg_if.sink   i_cfg
);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int LW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RB   = $clog2(2 * MAX_RADIUS + 2);
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int MW   = (CW > HW) ? ((CW > RB) ? CW : RB) : ((HW > RB) ? HW : RB);
    localparam int XW   = MW + 2;
    localparam int TW   = $clog2(2 * MAX_RADIUS + 2);
    localparam int SW   = sbb_pkg::PIX_W + $clog2(2 * MAX_RADIUS + 2);
    localparam int DW   = SW + 1;
    localparam int NW   = $clog2(4 * MAX_RADIUS + 3);
    localparam int RING = 1 << (RB + LW);

    function automatic logic signed [XW-1:0] mirror(input logic signed [XW-1:0] c,
                                                    input logic signed [XW-1:0] n);
        logic signed [XW-1:0] m;
        begin
            m = c;
            if (c < 0) m = -c;
            else if (c >= n) m = XW'(2 * n - 1 - c);
            if (m < 0) m = '0;
            if (m >= n) m = XW'(n - 1);
            return m;
        end
    endfunction

    // configuration, clamped into range
    logic [sbb_pkg::CFG_DW-1:0] r_cfg_w, r_cfg_h;
    logic [3:0]                 r_cfg_r;
    logic [CW-1:0] w;
    logic [HW-1:0] h;
    logic [RW-1:0] r;

    always_comb begin
        if (r_cfg_w == '0) w = CW'(1);
        else if (32'(r_cfg_w) > MAX_WIDTH) w = CW'(MAX_WIDTH);
        else w = CW'(r_cfg_w);
        if (r_cfg_h == '0) h = HW'(1);
        else if (32'(r_cfg_h) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
        else h = HW'(r_cfg_h);
        if (r_cfg_r == '0) r = RW'(1);
        else if (32'(r_cfg_r) > MAX_RADIUS) r = RW'(MAX_RADIUS);
        else r = RW'(r_cfg_r);
    end

    logic [2:0]  r_state;
    logic        r_vert;
    logic [CW-1:0] r_in_col, r_out_col, r_hx, r_hend;
    logic [HW-1:0] r_in_row, r_out_row;
    logic signed [XW-1:0] r_c;
    logic [TW-1:0] r_cnt;
    logic [SW-1:0] r_sum;
    logic          r_rd_vld;
    logic          r_div_run;
    logic          r_ovld;
    logic [15:0]   r_blur;
    logic          r_fend;

    logic [15:0] raw_mem [MAX_WIDTH];
    logic [15:0] ring_mem [RING];
    logic [15:0] r_raw_q, r_ring_q;

    logic in_acc, cfg_acc, absorb;
    logic signed [XW-1:0] tap;
    logic [XW-1:0] in_row_x, tap_u;
    logic [LW-1:0] raw_addr;
    logic [RB+LW-1:0] ring_rd_addr, ring_wr_addr;
    logic div_start, div_done;
    logic [DW-1:0] div_q;
    logic [CW:0] tx;
    logic [HW:0] ty;
    logic due, out_bad;
    logic signed [XW-1:0] hx_first;

    assign in_acc  = i_pix.valid && i_pix.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = (r_state == sbb_pkg::S_IDLE);
    assign absorb = (i_pix.kind == sbb_pkg::KIND_PIXEL) && (r_in_row < h) && (r_in_col < w);

    assign tap = r_vert ? mirror(r_c, XW'(h)) : mirror(r_c, XW'(w));
    assign tap_u = XW'(tap);
    assign raw_addr = tap_u[LW-1:0];
    assign ring_rd_addr = {tap_u[RB-1:0], LW'(r_out_col)};
    assign in_row_x = XW'(r_in_row);
    assign ring_wr_addr = {in_row_x[RB-1:0], LW'(r_hx)};

    assign tx = ((CW+1)'(r_out_col) + (CW+1)'(r) > (CW+1)'(w - 1'b1))
              ? (CW+1)'(w - 1'b1) : (CW+1)'(r_out_col) + (CW+1)'(r);
    assign ty = ((HW+1)'(r_out_row) + (HW+1)'(r) > (HW+1)'(h - 1'b1))
              ? (HW+1)'(h - 1'b1) : (HW+1)'(r_out_row) + (HW+1)'(r);
    assign due = (ty < (HW+1)'(r_in_row))
              || ((ty == (HW+1)'(r_in_row)) && (tx < (CW+1)'(r_in_col)));
    assign out_bad = (r_out_row >= h) || (r_out_col >= w);
    assign hx_first = (r_in_col >= CW'(r)) ? XW'(r_in_col - CW'(r)) : '0;

    assign div_start = (r_state == sbb_pkg::S_DIV) && !r_div_run;

    sbb_div #(.DW(DW), .NW(NW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DW'({r_sum, 1'b0}) + DW'({r, 1'b1})),
        .i_divisor  (NW'({r, 2'b10})),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // line stores
    always_ff @(posedge i_clk) begin
        if (in_acc && absorb) raw_mem[LW'(r_in_col)] <= i_pix.pixel;
        r_raw_q <= raw_mem[raw_addr];
        if (r_state == sbb_pkg::S_DIV && div_done && !r_vert) ring_mem[ring_wr_addr] <= div_q[15:0];
        r_ring_q <= ring_mem[ring_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sbb_pkg::S_IDLE;
            r_cfg_w   <= sbb_pkg::CFG_DW'(1024);
            r_cfg_h   <= sbb_pkg::CFG_DW'(1024);
            r_cfg_r   <= 4'd1;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_rd_vld  <= 1'b0;
            r_div_run <= 1'b0;
            r_ovld    <= 1'b0;
            r_vert    <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready) r_ovld <= 1'b0;
            if (div_start) r_div_run <= 1'b1;
            // tap data arrives in the cycle after its address
            if (r_rd_vld) r_sum <= r_sum + SW'(r_vert ? r_ring_q : r_raw_q);
            r_rd_vld <= (r_state == sbb_pkg::S_TAP);
            case (r_state)
                sbb_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_vert   <= 1'b0;
                        r_cnt    <= '0;
                        r_sum    <= '0;
                        if (!absorb) begin
                            r_state <= sbb_pkg::S_CHK;
                        end else if (r_in_col == w - 1'b1) begin
                            r_hx    <= CW'(hx_first);
                            r_hend  <= w - 1'b1;
                            r_c     <= hx_first - XW'(r);
                            r_state <= sbb_pkg::S_TAP;
                        end else if (r_in_col >= CW'(r)) begin
                            r_hx    <= r_in_col - CW'(r);
                            r_hend  <= r_in_col - CW'(r);
                            r_c     <= XW'(r_in_col) - XW'(2 * r);
                            r_state <= sbb_pkg::S_TAP;
                        end else begin
                            r_state <= sbb_pkg::S_ADV;
                        end
                    end
                end
                sbb_pkg::S_TAP: begin
                    r_c   <= r_c + 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == TW'(2 * r)) r_state <= sbb_pkg::S_LAST;
                end
                sbb_pkg::S_LAST: begin
                    r_state <= sbb_pkg::S_DIV;
                end
                sbb_pkg::S_DIV: begin
                    if (div_done) begin
                        r_div_run <= 1'b0;
                        if (r_vert) begin
                            r_state <= sbb_pkg::S_PUT;
                        end else if (r_hx == r_hend) begin
                            r_state <= sbb_pkg::S_ADV;
                        end else begin
                            r_hx    <= r_hx + 1'b1;
                            r_c     <= XW'(r_hx) + 1'b1 - XW'(r);
                            r_cnt   <= '0;
                            r_sum   <= '0;
                            r_state <= sbb_pkg::S_TAP;
                        end
                    end
                end
                sbb_pkg::S_ADV: begin
                    if (r_in_col + 1'b1 >= w) begin
                        r_in_col <= '0;
                        r_in_row <= r_in_row + 1'b1;
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                    r_state <= sbb_pkg::S_CHK;
                end
                sbb_pkg::S_CHK: begin
                    if (out_bad) begin
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_col <= '0;
                        r_out_row <= '0;
                        r_state   <= sbb_pkg::S_IDLE;
                    end else if (due) begin
                        r_vert  <= 1'b1;
                        r_c     <= XW'(r_out_row) - XW'(r);
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= sbb_pkg::S_TAP;
                    end else begin
                        r_state <= sbb_pkg::S_IDLE;
                    end
                end
                sbb_pkg::S_PUT: begin
                    // hold until the output register frees
                    if (!r_ovld || o_res.ready) begin
                        r_ovld  <= 1'b1;
                        r_blur  <= div_q[15:0];
                        r_fend  <= (r_out_col == w - 1'b1) && (r_out_row == h - 1'b1);
                        r_state <= sbb_pkg::S_IDLE;
                        if (r_out_col + 1'b1 >= w) begin
                            r_out_col <= '0;
                            if (r_out_row + 1'b1 >= h) begin
                                r_out_row <= '0;
                                r_in_col  <= '0;
                                r_in_row  <= '0;
                            end else begin
                                r_out_row <= r_out_row + 1'b1;
                            end
                        end else begin
                            r_out_col <= r_out_col + 1'b1;
                        end
                    end
                end
                default: r_state <= sbb_pkg::S_IDLE;
            endcase
            if (cfg_acc) begin
                case (i_cfg.index)
                    sbb_pkg::REG_WIDTH:  r_cfg_w <= i_cfg.data;
                    sbb_pkg::REG_HEIGHT: r_cfg_h <= i_cfg.data;
                    sbb_pkg::REG_RADIUS: r_cfg_r <= i_cfg.data[3:0];
                    default: ;
                endcase
                if (i_cfg.index inside {sbb_pkg::REG_WIDTH, sbb_pkg::REG_HEIGHT,
                                        sbb_pkg::REG_RADIUS}) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end
            end
        end
    end

    assign o_res.valid     = r_ovld;
    assign o_res.blurred   = r_blur;
    assign o_res.frame_end = r_fend;
endmodule
`default_nettype wire

>>> hdl/sbb_chk.sv
// Port-level checker for the blur core, bound into the core module.
`default_nettype none
module sbb_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_out_blurred,
    input wire logic        i_out_frame_end,
    input wire logic        i_cfg_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_blurred)
            && $stable(i_out_frame_end))
        else $error("output word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken on back-to-back cycles");

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without work in progress");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config port not ready");
endmodule

bind separable_box_blur_core sbb_chk u_sbb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_blurred   (o_res.blurred),
    .i_out_frame_end (o_res.frame_end),
    .i_cfg_ready     (i_cfg.ready)
);
`default_nettype wire

>>> tb/tb_sbb_if.sv
// Shared testbench types for checking blurred output words.
package tb_sbb_types;
    typedef struct packed {
        logic [15:0] blurred;
        logic        frame_end;
    } t_blur_word;
endpackage

>>> tb/tb_top.sv
// Self-checking testbench for the separable box blur core: directed, abandoned, tall and random frames.
module tb_top;
    localparam int MAXW = 1024;
    localparam int MAXR = 15;
    localparam int RING = 2 * MAXR + 2;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sbb_in_if  pix_ch ();
    sbb_out_if res_ch ();
    sbb_cfg_if cfg_ch ();

    separable_box_blur_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] row_raw [MAXW];
    logic [15:0] hpass [RING * MAXW];
    int unsigned in_col, in_rw, out_col, out_rw;
    logic [10:0] reg_w = 11'd1024, reg_h = 11'd1024;
    logic [3:0]  reg_r = 4'd1;

    tb_sbb_types::t_blur_word blur_queue[$];
    int mismatches = 0;
    int words_seen = 0;
    int items_sent = 0;
    bit stall_free = 1'b0;

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned reflect(int c, int n);
        if (c < 0) c = -c;
        else if (c >= n) c = 2 * n - 1 - c;
        if (c < 0) c = 0;
        if (c >= n) c = n - 1;
        return c;
    endfunction

    function automatic logic [15:0] mean_half_up(int unsigned sum, int unsigned r);
        int unsigned n;
        n = 2 * r + 1;
        return 16'((2 * sum + n) / (2 * n));
    endfunction

    task automatic row_mean(int unsigned x, int unsigned w, int unsigned r);
        int unsigned sum;
        sum = 0;
        for (int k = -int'(r); k <= int'(r); k++)
            sum += row_raw[reflect(int'(x) + k, int'(w)) % MAXW];
        hpass[(in_rw % RING) * MAXW + (x % MAXW)] = mean_half_up(sum, r);
    endtask

    task automatic predict_blur(logic kind, logic [15:0] px_val);
        int unsigned w, h, r, tx, ty, sum, cy, x;
        tb_sbb_types::t_blur_word wd;
        w = clampu(reg_w, 1, MAXW);
        h = clampu(reg_h, 1, 1024);
        r = clampu(reg_r, 1, MAXR);
        if (kind == sbb_pkg::KIND_PIXEL && in_rw < h && in_col < w) begin
            row_raw[in_col % MAXW] = px_val;
            if (in_col == w - 1) begin
                for (x = (in_col >= r) ? in_col - r : 0; x < w; x++) row_mean(x, w, r);
            end else if (in_col >= r) begin
                row_mean(in_col - r, w, r);
            end
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_rw++;
            end
        end
        if (out_rw >= h || out_col >= w) begin
            in_col = 0; in_rw = 0; out_col = 0; out_rw = 0;
            return;
        end
        tx = (out_col + r > w - 1) ? w - 1 : out_col + r;
        ty = (out_rw + r > h - 1) ? h - 1 : out_rw + r;
        if (!(ty < in_rw || (ty == in_rw && tx < in_col))) return;
        sum = 0;
        for (int k = -int'(r); k <= int'(r); k++) begin
            cy = reflect(int'(out_rw) + k, int'(h));
            sum += hpass[(cy % RING) * MAXW + (out_col % MAXW)];
        end
        wd.blurred = mean_half_up(sum, r);
        wd.frame_end = (out_col == w - 1 && out_rw == h - 1);
        blur_queue.push_back(wd);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_rw++;
            if (out_rw >= h) begin
                in_col = 0; in_rw = 0; out_col = 0; out_rw = 0;
            end
        end
    endtask

    function automatic int gap();
        return stall_free ? 0 : $urandom_range(0, 11);
    endfunction

    // output side: ready with random stalls unless stall_free is set, check each word
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready = (gap() == 0) || ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            words_seen++;
            if (blur_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word blurred=%h frame_end=%b",
                             res_ch.blurred, res_ch.frame_end);
            end else begin
                tb_sbb_types::t_blur_word e;
                e = blur_queue.pop_front();
                if (e.blurred !== res_ch.blurred || e.frame_end !== res_ch.frame_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b got %h/%b", e.blurred,
                                 e.frame_end, res_ch.blurred, res_ch.frame_end);
                end
            end
        end
    end

    task automatic send_word(logic kind, logic [15:0] px_val);
        int d;
        d = gap();
        repeat (d) @(negedge i_clk);
        pix_ch.kind  = kind;
        pix_ch.pixel = px_val;
        pix_ch.valid = 1'b1;
        do @(posedge i_clk); while (!pix_ch.ready);
        predict_blur(kind, px_val);
        items_sent++;
        @(negedge i_clk);
        pix_ch.valid = 1'b0;
    endtask

    task automatic settle();
        wait (blur_queue.size() == 0);
        // block may still be working on an item that gives no word
        repeat (1200) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            sbb_pkg::REG_WIDTH:  reg_w = val;
            sbb_pkg::REG_HEIGHT: reg_h = val;
            sbb_pkg::REG_RADIUS: reg_r = val[3:0];
            default: ;
        endcase
        in_col = 0; in_rw = 0; out_col = 0; out_rw = 0;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_frame(logic [10:0] w, logic [10:0] h, logic [10:0] r);
        settle();
        write_reg(sbb_pkg::REG_WIDTH, w);
        write_reg(sbb_pkg::REG_HEIGHT, h);
        write_reg(sbb_pkg::REG_RADIUS, r);
    endtask

    // feed a whole frame, then drain ticks until the frame's last word is due
    task automatic run_frame(bit extremes);
        int unsigned n, pend;
        logic [15:0] v;
        n = clampu(reg_w, 1, MAXW) * clampu(reg_h, 1, 1024);
        for (int i = 0; i < n; i++) begin
            if (extremes) v = (i % 2) ? 16'hFFFF : 16'h0000;
            else v = 16'($urandom());
            send_word(sbb_pkg::KIND_PIXEL, v);
            if ($urandom_range(0, 15) == 0) send_word(sbb_pkg::KIND_DRAIN, 16'($urandom()));
        end
        pend = 0;
        while (in_rw != 0 || out_rw != 0 || out_col != 0) begin
            // a stray pixel after the frame is ignored but still drains
            send_word(($urandom_range(0, 5) == 0) ? sbb_pkg::KIND_PIXEL : sbb_pkg::KIND_DRAIN,
                      16'($urandom()));
            if (++pend > 4000) break;
        end
    endtask

    task automatic test_directed();
        set_frame(11'd3, 11'd2, 11'd1);
        run_frame(1'b1);
        set_frame(11'd1, 11'd1, 11'd0);
        send_word(sbb_pkg::KIND_DRAIN, 16'h0);
        send_word(sbb_pkg::KIND_PIXEL, 16'hFFFF);
        send_word(sbb_pkg::KIND_PIXEL, 16'h1234);
        set_frame(11'd4, 11'd3, 11'd15);
        run_frame(1'b1);
    endtask

    task automatic test_abandon();
        set_frame(11'd5, 11'd4, 11'd2);
        for (int i = 0; i < 7; i++) send_word(sbb_pkg::KIND_PIXEL, 16'($urandom()));
        set_frame(11'd2, 11'd3, 11'd1);
        run_frame(1'b0);
    endtask

    task automatic test_random();
        logic [10:0] w, h;
        while (items_sent < 1250) begin
            // allow wide frames only early so the item count stays near its target
            w = (items_sent < 100 && $urandom_range(0, 9) == 0)
                ? 11'($urandom_range(0, 2047)) : 11'($urandom_range(1, 12));
            h = 11'($urandom_range(0, 6));
            if (w > 40) h = 11'($urandom_range(0, 1));
            set_frame(w, h, 11'($urandom_range(0, 15)));
            stall_free = ($urandom_range(0, 3) == 0);
            run_frame(1'b0);
            stall_free = 1'b0;
        end
    endtask

    task automatic test_tall_frame();
        set_frame(11'd1, 11'd2047, 11'd15);
        for (int i = 0; i < 40; i++) send_word(sbb_pkg::KIND_PIXEL, 16'($urandom()));
        set_frame(11'd3, 11'd3, 11'd1);
        run_frame(1'b0);
    endtask

    initial begin
        pix_ch.valid = 1'b0;
        pix_ch.kind = sbb_pkg::KIND_PIXEL;
        pix_ch.pixel = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = sbb_pkg::REG_WIDTH;
        cfg_ch.data = '0;
        for (int i = 0; i < MAXW; i++) row_raw[i] = '0;
        for (int i = 0; i < RING * MAXW; i++) hpass[i] = '0;
        in_col = 0; in_rw = 0; out_col = 0; out_rw = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_abandon();
        test_tall_frame();
        test_random();
        settle();
        $display("Covered %0d input words and %0d blurred words over many frame sizes and radii.",
                 items_sent, words_seen);
        if (mismatches == 0 && blur_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #300000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
